FILE: src/heightmap_box_smooth_3x3_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the height map box smoothing unit
// Shorthand for clocked implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_MACROS_SVH
`define HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_MACROS_SVH

// Same-cycle implication.
`define HBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/hbs_pkg.sv
// ----------------------------------------------------------------------------
// Height map box smoothing package
// Field widths, register codes, controller states and the command and
// status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int CMD_W      = 1;
  localparam int SAMPLE_W   = 8;
  localparam int SMOOTHED_W = 16;

  localparam int COLUMNS_W = 11;
  localparam int ROWS_W    = 13;
  localparam int SCALE_W   = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE   = 2'd2;

  localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 11'd256;
  localparam logic [ROWS_W-1:0]    ROWS_RESET    = 13'd256;
  localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd256;

  localparam logic [CMD_W-1:0] CMD_DRAIN = 1'b1;

  localparam int ROW_W = 16;
  localparam logic [ROW_W-1:0] ROW_CAP = '1;

  localparam int SUM_W  = 12;
  localparam int DIV_W  = 12;
  localparam int QUOT_W = SMOOTHED_W;
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam int STEP_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic sum;
    logic mul;
    logic check;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic primed;
    logic sat;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: src/hbs_ifs.sv
// ----------------------------------------------------------------------------
// Height map box smoothing channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface hbs_item_if;
  import hbs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, cmd, sample, input ready);
  modport sink (input valid, cmd, sample, output ready);
endinterface

interface hbs_result_if;
  import hbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SMOOTHED_W-1:0] smoothed;
  logic                  frame_end;
  modport source (output valid, smoothed, frame_end, input ready);
  modport sink (input valid, smoothed, frame_end, output ready);
endinterface

interface hbs_cfg_if;
  import hbs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/heightmap_box_smooth_3x3_unit.sv
// ----------------------------------------------------------------------------
// Height map 3x3 box smoothing unit
// Takes 8-bit height samples in raster order and returns, for each pixel,
// floor(sum * height_scale / (255 * count)) over its in-image 3x3
// neighborhood as unsigned Q8.8, saturated at 0xFFFF, lagging the samples
// by columns+1 words; columns+1 drain words after the last sample flush the
// frame and the last pixel carries frame_end. Words are taken one at a
// time: a word with a result passes the line buffer update, window sum,
// multiply, saturation check, 16-step bit-serial divider (skipped on
// saturation) and output load; a word with no result stops after the
// update. A finished result waits in the output register while the next
// word is taken. The two line buffers are MAX_COLUMNS x 8 memories with
// no clearing pass; the register port is always ready.
// ----------------------------------------------------------------------------
module heightmap_box_smooth_3x3_unit #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 4096
) (
  input  logic          clk,
  input  logic          rst,
  hbs_cfg_if.sink       cfg,
  hbs_item_if.sink      samples,
  hbs_result_if.source  results
);
  import hbs_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  hbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  hbs_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .item_cmd    (samples.cmd),
    .item_sample (samples.sample),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .smoothed    (results.smoothed),
    .frame_end   (results.frame_end),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule

FILE: src/hbs_ctrl.sv
// ----------------------------------------------------------------------------
// Height map box smoothing controller
// Sequences one word at a time through line buffer update and, once primed,
// window sum, scaling multiply and the bit-serial divider.
// ----------------------------------------------------------------------------
module hbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hbs_pkg::dp_sts_t sts,
  output hbs_pkg::dp_cmd_t ctl
);
  import hbs_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CHECK) begin
        step <= '0;
      end else if (state == ST_DIV) begin
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !sts.skip) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = sts.primed ? ST_SUM : ST_IDLE;
      end
      ST_SUM:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = sts.sat ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(QUOT_W - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      ST_UPDATE: ctl.update   = 1'b1;
      ST_SUM:    ctl.sum      = 1'b1;
      ST_MUL:    ctl.mul      = 1'b1;
      ST_CHECK:  ctl.check    = 1'b1;
      ST_DIV:    ctl.div_step = 1'b1;
      ST_OUT:    ctl.load_out = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: src/hbs_datapath.sv
// ----------------------------------------------------------------------------
// Height map box smoothing datapath
// Registers, two line buffers, the 3x3 window, position counters, the
// scaling multiplier, a restoring divider and the result register.
// ----------------------------------------------------------------------------
`include "heightmap_box_smooth_3x3_unit_macros.svh"

module hbs_datapath #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [hbs_pkg::CMD_W-1:0]       item_cmd,
  input  logic [hbs_pkg::SAMPLE_W-1:0]    item_sample,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [hbs_pkg::SMOOTHED_W-1:0]  smoothed,
  output logic                            frame_end,
  input  hbs_pkg::dp_cmd_t                ctl,
  output hbs_pkg::dp_sts_t                sts
);
  import hbs_pkg::*;

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CCMP_W = CNT_W + 1;
  localparam int NROW_W = $clog2(MAX_ROWS + 1);
  localparam int RCMP_W = (NROW_W > ROW_W + 1) ? NROW_W : ROW_W + 1;

  logic [COLUMNS_W-1:0] columns;
  logic [ROWS_W-1:0]    rows;
  logic [SCALE_W-1:0]   height_scale;

  logic [SAMPLE_W-1:0] line_a [MAX_COLUMNS];
  logic [SAMPLE_W-1:0] line_b [MAX_COLUMNS];
  logic [SAMPLE_W-1:0] rd_top;
  logic [SAMPLE_W-1:0] rd_mid;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] win [3][3];

  logic [COL_W-1:0]  in_col;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  in_row;
  logic [ROW_W-1:0]  out_row;
  logic [CNT_W-1:0]  eff_cols;
  logic [NROW_W-1:0] eff_rows;
  logic              in_col_end;
  logic              out_col_end;
  logic              out_row_end;
  logic              last;
  logic              last_q;

  logic             use_l;
  logic             use_r;
  logic             use_t;
  logic             use_b;
  logic [1:0]       ncol;
  logic [1:0]       nrow;
  logic [3:0]       count;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_q;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] divisor_q;

  logic [PROD_W-1:0] prod;
  logic              sat;
  logic [DIV_W-1:0]  rem;
  logic [QUOT_W-1:0] quot;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    trial_diff;
  logic              trial_ge;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= COLUMNS_RESET;
      rows         <= ROWS_RESET;
      height_scale <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLUMNS: columns      <= cfg_data[COLUMNS_W-1:0];
        CFG_ROWS:    rows         <= cfg_data[ROWS_W-1:0];
        CFG_SCALE:   height_scale <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (columns == '0) begin
      eff_cols = CNT_W'(1);
    end else if (32'(columns) > 32'(MAX_COLUMNS)) begin
      eff_cols = CNT_W'(MAX_COLUMNS);
    end else begin
      eff_cols = CNT_W'(columns);
    end
    if (rows == '0) begin
      eff_rows = NROW_W'(1);
    end else if (32'(rows) > 32'(MAX_ROWS)) begin
      eff_rows = NROW_W'(MAX_ROWS);
    end else begin
      eff_rows = NROW_W'(rows);
    end
  end

  assign in_col_end  = (CCMP_W'(in_col) + CCMP_W'(1)) >= CCMP_W'(eff_cols);
  assign out_col_end = (CCMP_W'(out_col) + CCMP_W'(1)) >= CCMP_W'(eff_cols);
  assign out_row_end = (RCMP_W'(out_row) + RCMP_W'(1)) >= RCMP_W'(eff_rows);
  assign last        = out_col_end && out_row_end;

  assign sts.skip     = (item_cmd == CMD_DRAIN) && (in_row == '0) && (in_col == '0);
  assign sts.primed   = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign sts.sat      = sat;
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rd_top   <= line_a[in_col];
      rd_mid   <= line_b[in_col];
      sample_q <= (item_cmd == CMD_DRAIN) ? '0 : item_sample;
    end
    if (ctl.update) begin
      line_a[in_col] <= rd_mid;
      line_b[in_col] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{default: '0};
    end else if (ctl.update) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= rd_top;
      win[2][1] <= rd_mid;
      win[2][2] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (ctl.update) begin
        if (in_col_end) begin
          in_col <= '0;
          if (in_row != ROW_CAP) in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (ctl.sum) begin
        if (last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_end) begin
          out_col <= '0;
          if (out_row != ROW_CAP) out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  always_comb begin
    use_l = (out_col != '0);
    use_r = !out_col_end;
    use_t = (out_row != '0);
    use_b = !out_row_end;
    sum   = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if ((c != 0 || use_l) && (c != 2 || use_r) && (r != 0 || use_t) && (r != 2 || use_b)) begin
          sum = sum + SUM_W'(win[c][r]);
        end
      end
    end
    ncol    = 2'd1 + 2'(use_l) + 2'(use_r);
    nrow    = 2'd1 + 2'(use_t) + 2'(use_b);
    count   = {2'b00, ncol} * {2'b00, nrow};
    divisor = {count, 8'h00} - DIV_W'(count);
  end

  assign sat        = prod >= {divisor_q, {QUOT_W{1'b0}}};
  assign trial      = {rem, quot[QUOT_W-1]};
  assign trial_ge   = trial >= {1'b0, divisor_q};
  assign trial_diff = trial - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      sum_q     <= sum;
      divisor_q <= divisor;
      last_q    <= last;
    end
    if (ctl.mul) begin
      prod <= PROD_W'(sum_q) * PROD_W'(height_scale);
    end
    if (ctl.check) begin
      if (sat) begin
        rem  <= '0;
        quot <= '1;
      end else begin
        rem  <= prod[PROD_W-1 -: DIV_W];
        quot <= prod[QUOT_W-1:0];
      end
    end else if (ctl.div_step) begin
      rem  <= trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quot <= {quot[QUOT_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      smoothed  <= quot;
      frame_end <= last_q;
    end
  end

  `HBS_ASSERT_IMP(a_out_no_overwrite, ctl.load_out, !res_valid || res_ready, "result word overwritten before it was taken")
  `HBS_ASSERT_NEXT(a_div_rem_bound, ctl.check || ctl.div_step, rem < divisor_q, "divider remainder not below divisor")
  `HBS_ASSERT_IMP(a_div_legal, ctl.mul || ctl.check, divisor_q == DIV_W'(255) || divisor_q == DIV_W'(510) || divisor_q == DIV_W'(765) || divisor_q == DIV_W'(1020) || divisor_q == DIV_W'(1530) || divisor_q == DIV_W'(2295), "divisor is not 255 times a legal neighbor count")

endmodule
